FILE: src/binary_weight_conv_threshold_unit_assert.svh
// Assertion macros shared by the convolution threshold unit RTL.
// Depends on nothing; files that check their own logic include it.
`ifndef BINARY_WEIGHT_CONV_THRESHOLD_UNIT_ASSERT_SVH
`define BINARY_WEIGHT_CONV_THRESHOLD_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Implication checked in the same cycle.
`define BWCT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");
// Implication checked in the next cycle.
`define BWCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define BWCT_ASSERT_NOW(label, clk, rst, ante, cons)
`define BWCT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: src/bwct_pkg.sv
// Shared constants, codes and types of the convolution threshold unit.
// Depends on nothing; the interfaces and modules refer to it by scoped names.
package bwct_pkg;

  // Default values of the top-level parameters.
  localparam int KERNEL_SIZE_DEF = 3;
  localparam int CHANNELS_DEF    = 8;
  localparam int MAX_WIDTH_DEF   = 128;
  localparam int MAX_HEIGHT_DEF  = 128;
  localparam int PIXEL_WIDTH_DEF = 16;

  // Fixed widths of the channel payloads.
  localparam int OPCODE_W       = 2;
  localparam int CH_IDX_W       = 3;
  localparam int PIXEL_VALUE_W  = 16;
  localparam int WEIGHT_BITS_W  = 9;
  localparam int CHANNEL_BITS_W = 8;
  localparam int CFG_ADDR_W     = 1;
  localparam int CFG_DATA_W     = 8;

  // Reset value of both image size registers.
  localparam logic [CFG_DATA_W-1:0] SIZE_RESET = 8'd128;

  // Item opcodes; the fourth code is unused and dropped.
  typedef enum logic [OPCODE_W-1:0] {
    OP_PIXEL  = 2'd0,
    OP_WEIGHT = 2'd1,
    OP_THRESH = 2'd2
  } op_t;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_IMAGE_WIDTH  = 1'd0,
    REG_IMAGE_HEIGHT = 1'd1
  } reg_idx_t;

  // Control part of an item that travels down the channel chain.
  typedef struct packed {
    logic                valid;
    op_t                 op;
    logic [CH_IDX_W-1:0] ch;
    logic                last;
  } ctl_t;

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

FILE: src/bwct_ifs.sv
// Valid/ready channel interfaces: input items, result items, register writes.
// Depends on bwct_pkg for the payload widths.
interface bwct_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [bwct_pkg::OPCODE_W-1:0]        opcode;
  logic [bwct_pkg::CH_IDX_W-1:0]        channel_index;
  logic signed [bwct_pkg::PIXEL_VALUE_W-1:0] pixel_value;
  logic [bwct_pkg::WEIGHT_BITS_W-1:0]   weight_bits;

  modport source (output valid, opcode, channel_index, pixel_value, weight_bits,
                  input ready);
  modport sink (input valid, opcode, channel_index, pixel_value, weight_bits,
                output ready);
endinterface

interface bwct_out_if;
  logic                                valid;
  logic                                ready;
  logic [bwct_pkg::CHANNEL_BITS_W-1:0] channel_bits;
  logic                                frame_last;

  modport source (output valid, channel_bits, frame_last, input ready);
  modport sink (input valid, channel_bits, frame_last, output ready);
endinterface

interface bwct_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bwct_pkg::CFG_ADDR_W-1:0] index;
  logic [bwct_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: src/bwct_window.sv
// Front end: raster counters, line memory and KxK window of the unit.
// Depends on bwct_pkg and the assertion macro header.
`include "binary_weight_conv_threshold_unit_assert.svh"

module bwct_window #(
  parameter int KERNEL_SIZE = bwct_pkg::KERNEL_SIZE_DEF,
  parameter int MAX_WIDTH   = bwct_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = bwct_pkg::MAX_HEIGHT_DEF,
  parameter int PIXEL_WIDTH = bwct_pkg::PIXEL_WIDTH_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      en,
  input  logic                                      in_valid,
  input  logic [bwct_pkg::OPCODE_W-1:0]             opcode,
  input  logic [bwct_pkg::CH_IDX_W-1:0]             channel_index,
  input  logic signed [bwct_pkg::PIXEL_VALUE_W-1:0] pixel_value,
  input  logic [bwct_pkg::WEIGHT_BITS_W-1:0]        weight_bits,
  input  logic [bwct_pkg::CFG_DATA_W-1:0]           image_width,
  input  logic [bwct_pkg::CFG_DATA_W-1:0]           image_height,
  output bwct_pkg::ctl_t                            head_ctl,
  output logic [KERNEL_SIZE*KERNEL_SIZE*PIXEL_WIDTH-1:0] head_win
);

  localparam int KK    = KERNEL_SIZE * KERNEL_SIZE;
  localparam int PW    = PIXEL_WIDTH;
  localparam int MW    = (KERNEL_SIZE - 1) * PW;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int WSZ_W = bwct_pkg::max_int($clog2(MAX_WIDTH + 1), bwct_pkg::CFG_DATA_W);
  localparam int HSZ_W = bwct_pkg::max_int($clog2(MAX_HEIGHT + 1), bwct_pkg::CFG_DATA_W);

  bwct_pkg::op_t in_op;
  logic          accept;
  logic          acc_pix;
  logic          op_known;

  logic [WSZ_W-1:0] w_raw;
  logic [WSZ_W-1:0] w_eff;
  logic [HSZ_W-1:0] h_raw;
  logic [HSZ_W-1:0] h_eff;
  logic [CW-1:0]    col;
  logic [RW-1:0]    row;
  logic [WSZ_W-1:0] col_p1;
  logic [HSZ_W-1:0] row_p1;
  logic             col_wrap;
  logic             row_wrap;
  logic             emit_now;

  logic                       s0_valid;
  bwct_pkg::op_t              s0_op;
  logic [bwct_pkg::CH_IDX_W-1:0] s0_ch;
  logic                       s0_emit;
  logic                       s0_last;
  logic signed [PW-1:0]       s0_px;
  logic [KK-1:0]              s0_wgt;
  logic [CW-1:0]              s0_col;

  logic [MW-1:0] mem [MAX_WIDTH];
  logic [MW-1:0] rd_q;
  logic [MW-1:0] mem_wd;
  logic          mem_we;

  logic signed [PW-1:0] win      [KERNEL_SIZE][KERNEL_SIZE];
  logic signed [PW-1:0] win_next [KERNEL_SIZE][KERNEL_SIZE];
  logic [KK*PW-1:0]     win_flat;

  assign in_op    = bwct_pkg::op_t'(opcode);
  assign accept   = in_valid && en;
  assign acc_pix  = accept && (in_op == bwct_pkg::OP_PIXEL);
  assign op_known = (in_op == bwct_pkg::OP_PIXEL) || (in_op == bwct_pkg::OP_WEIGHT) ||
                    (in_op == bwct_pkg::OP_THRESH);

  // Effective frame size, clamped to one through the maximum.
  assign w_raw = WSZ_W'(image_width);
  assign h_raw = HSZ_W'(image_height);
  assign w_eff = (w_raw == '0) ? WSZ_W'(1) :
                 (w_raw > WSZ_W'(MAX_WIDTH)) ? WSZ_W'(MAX_WIDTH) : w_raw;
  assign h_eff = (h_raw == '0) ? HSZ_W'(1) :
                 (h_raw > HSZ_W'(MAX_HEIGHT)) ? HSZ_W'(MAX_HEIGHT) : h_raw;

  // Position decode for the pixel being accepted.
  assign col_p1   = WSZ_W'(col) + WSZ_W'(1);
  assign row_p1   = HSZ_W'(row) + HSZ_W'(1);
  assign col_wrap = col_p1 >= w_eff;
  assign row_wrap = row_p1 >= h_eff;
  assign emit_now = (row >= RW'(KERNEL_SIZE - 1)) && (col >= CW'(KERNEL_SIZE - 1));

  // Raster counters advance on every accepted pixel.
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (acc_pix) begin
      if (col_wrap) begin
        col <= '0;
        row <= row_wrap ? '0 : RW'(row_p1);
      end else begin
        col <= CW'(col_p1);
      end
    end
  end

  // Input register stage; the line memory read is issued alongside.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= accept && op_known;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_op   <= in_op;
      s0_ch   <= channel_index;
      s0_emit <= emit_now;
      s0_last <= col_wrap && row_wrap;
      s0_px   <= PW'($unsigned(pixel_value));
      s0_wgt  <= KK'(weight_bits);
      s0_col  <= col;
    end
  end

  // Line memory: one word per column holds the K-1 buffered rows.
  // A write to the column being read in the same cycle is forwarded.
  assign mem_we = en && s0_valid && (s0_op == bwct_pkg::OP_PIXEL);

  always_comb begin
    for (int i = 0; i < KERNEL_SIZE - 2; i++) begin
      mem_wd[i*PW +: PW] = rd_q[(i+1)*PW +: PW];
    end
    mem_wd[(KERNEL_SIZE-2)*PW +: PW] = s0_px;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[s0_col] <= mem_wd;
    end
    if (accept) begin
      rd_q <= (mem_we && (s0_col == col)) ? mem_wd : mem[col];
    end
  end

  // Window shifts left by one column; the new column comes from the line
  // memory with the fresh pixel at the bottom.
  always_comb begin
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      for (int j = 0; j < KERNEL_SIZE - 1; j++) begin
        win_next[i][j] = win[i][j+1];
      end
    end
    for (int i = 0; i < KERNEL_SIZE - 1; i++) begin
      win_next[i][KERNEL_SIZE-1] = rd_q[i*PW +: PW];
    end
    win_next[KERNEL_SIZE-1][KERNEL_SIZE-1] = s0_px;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      win <= win_next;
    end
  end

  always_comb begin
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      for (int j = 0; j < KERNEL_SIZE; j++) begin
        win_flat[(i*KERNEL_SIZE+j)*PW +: PW] = win_next[i][j];
      end
    end
  end

  // Head of the channel chain. Load items carry their data in the low
  // bits of the window field; pixels without a full window become bubbles.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_ctl <= '0;
    end else if (en) begin
      head_ctl.valid <= s0_valid && ((s0_op != bwct_pkg::OP_PIXEL) || s0_emit);
      head_ctl.op    <= s0_op;
      head_ctl.ch    <= s0_ch;
      head_ctl.last  <= s0_last;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (s0_op)
        bwct_pkg::OP_WEIGHT: head_win <= (KK*PW)'(s0_wgt);
        bwct_pkg::OP_THRESH: head_win <= (KK*PW)'($unsigned(s0_px));
        default:             head_win <= win_flat;
      endcase
    end
  end

  `BWCT_ASSERT_NEXT(a_col_step, clk, rst, acc_pix && !col_wrap, col == $past(col) + 1'b1)
  `BWCT_ASSERT_NEXT(a_frame_wrap, clk, rst, acc_pix && col_wrap && row_wrap,
                    (row == '0) && (col == '0))

endmodule

FILE: src/bwct_cell.sv
// One channel cell: holds that channel's weights and threshold, adds or
// subtracts the window pixels and sets its result bit. Depends on bwct_pkg.
`include "binary_weight_conv_threshold_unit_assert.svh"

module bwct_cell #(
  parameter int KERNEL_SIZE = bwct_pkg::KERNEL_SIZE_DEF,
  parameter int PIXEL_WIDTH = bwct_pkg::PIXEL_WIDTH_DEF,
  parameter int CHANNELS    = bwct_pkg::CHANNELS_DEF,
  parameter int CELL_ID     = 0
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           en,
  input  bwct_pkg::ctl_t                                 a_ctl,
  input  logic [KERNEL_SIZE*KERNEL_SIZE*PIXEL_WIDTH-1:0] a_win,
  input  logic [CHANNELS-1:0]                            a_bits,
  output bwct_pkg::ctl_t                                 o_ctl,
  output logic [KERNEL_SIZE*KERNEL_SIZE*PIXEL_WIDTH-1:0] o_win,
  output logic [CHANNELS-1:0]                            o_bits
);

  localparam int KK  = KERNEL_SIZE * KERNEL_SIZE;
  localparam int PW  = PIXEL_WIDTH;
  localparam int RSW = PW + $clog2(KERNEL_SIZE) + 1;
  localparam int AW  = PW + $clog2(KK) + 1;

  logic [KK-1:0]        wgt;
  logic signed [PW-1:0] thr;
  logic                 hit_a;
  logic                 hit_m;
  logic                 ld_wgt;
  logic                 ld_thr;

  logic signed [RSW-1:0] rs_next [KERNEL_SIZE];
  logic signed [RSW-1:0] m_rs    [KERNEL_SIZE];
  bwct_pkg::ctl_t        m_ctl;
  logic [KK*PW-1:0]      m_win;
  logic [CHANNELS-1:0]   m_bits;

  logic signed [AW-1:0]  total;
  logic                  ge;
  logic [CHANNELS-1:0]   o_bits_next;

  assign hit_a  = (int'(a_ctl.ch) == CELL_ID);
  assign hit_m  = (int'(m_ctl.ch) == CELL_ID);
  assign ld_wgt = a_ctl.valid && (a_ctl.op == bwct_pkg::OP_WEIGHT) && hit_a;
  assign ld_thr = m_ctl.valid && (m_ctl.op == bwct_pkg::OP_THRESH) && hit_m;

  // First half: signed partial sum of each window row.
  always_comb begin
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      rs_next[i] = '0;
      for (int j = 0; j < KERNEL_SIZE; j++) begin
        if (wgt[i*KERNEL_SIZE+j]) begin
          rs_next[i] = rs_next[i] + RSW'($signed(a_win[(i*KERNEL_SIZE+j)*PW +: PW]));
        end else begin
          rs_next[i] = rs_next[i] - RSW'($signed(a_win[(i*KERNEL_SIZE+j)*PW +: PW]));
        end
      end
    end
  end

  // Weights change as a load passes the first half, so items ahead of it
  // used the old pattern and items behind it use the new one.
  always_ff @(posedge clk) begin
    if (rst) begin
      wgt <= '0;
    end else if (en && ld_wgt) begin
      wgt <= a_win[KK-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_ctl <= '0;
    end else if (en) begin
      m_ctl <= a_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_rs   <= rs_next;
      m_win  <= a_win;
      m_bits <= a_bits;
    end
  end

  // Second half: add the row sums and compare with the threshold.
  always_comb begin
    total = '0;
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      total = total + AW'(m_rs[i]);
    end
  end

  assign ge = total >= AW'(thr);

  always_comb begin
    o_bits_next          = m_bits;
    o_bits_next[CELL_ID] = ge && m_ctl.valid && (m_ctl.op == bwct_pkg::OP_PIXEL);
  end

  // The threshold likewise changes as its load passes the second half.
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= '0;
    end else if (en && ld_thr) begin
      thr <= $signed(m_win[PW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_ctl <= '0;
    end else if (en) begin
      o_ctl <= m_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_win  <= m_win;
      o_bits <= o_bits_next;
    end
  end

  `BWCT_ASSERT_NEXT(a_wgt_hold, clk, rst, !(en && ld_wgt), $stable(wgt))
  `BWCT_ASSERT_NEXT(a_thr_hold, clk, rst, !(en && ld_thr), $stable(thr))

endmodule

FILE: src/binary_weight_conv_threshold_unit.sv
// Top level of the binarized KxK convolution with per-channel threshold.
// Depends on bwct_pkg, bwct_ifs, bwct_window, bwct_cell and the macro header.
//
//   Port     Modport  Beat carries
//   items    sink     opcode, channel_index, pixel_value, weight_bits
//   results  source   channel_bits, frame_last
//   cfg      sink     index, data (image_width, image_height)
//
// One item is taken per cycle while items.ready is high. After its pixel, a result
// passes the input stage, window stage, two stages in each channel cell and output.
// A waiting result with results.ready low freezes the whole pipeline, and
// items.ready follows that freeze in the same cycle.
// Reset clears the raster counters, weights, thresholds and valid bits; the
// line memory and the window are not cleared and are filled by the pixels.
`include "binary_weight_conv_threshold_unit_assert.svh"

module binary_weight_conv_threshold_unit #(
  parameter int KERNEL_SIZE = bwct_pkg::KERNEL_SIZE_DEF,
  parameter int CHANNELS    = bwct_pkg::CHANNELS_DEF,
  parameter int MAX_WIDTH   = bwct_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = bwct_pkg::MAX_HEIGHT_DEF,
  parameter int PIXEL_WIDTH = bwct_pkg::PIXEL_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst,
  bwct_in_if.sink    items,
  bwct_out_if.source results,
  bwct_cfg_if.sink   cfg
);

  localparam int KK = KERNEL_SIZE * KERNEL_SIZE;
  localparam int PW = PIXEL_WIDTH;

  logic                            adv;
  logic [bwct_pkg::CFG_DATA_W-1:0] image_width;
  logic [bwct_pkg::CFG_DATA_W-1:0] image_height;

  bwct_pkg::ctl_t      chain_ctl  [CHANNELS+1];
  logic [KK*PW-1:0]    chain_win  [CHANNELS+1];
  logic [CHANNELS-1:0] chain_bits [CHANNELS+1];

  logic                                res_valid;
  logic [bwct_pkg::CHANNEL_BITS_W-1:0] res_bits;
  logic                                res_last;

  // The pipeline moves whenever the output register is free or being read.
  assign adv         = !res_valid || results.ready;
  assign items.ready = adv;
  assign cfg.ready   = 1'b1;

  // Image size registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= bwct_pkg::SIZE_RESET;
      image_height <= bwct_pkg::SIZE_RESET;
    end else if (cfg.valid) begin
      unique case (bwct_pkg::reg_idx_t'(cfg.index))
        bwct_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg.data;
        bwct_pkg::REG_IMAGE_HEIGHT: image_height <= cfg.data;
      endcase
    end
  end

  bwct_window #(
    .KERNEL_SIZE (KERNEL_SIZE),
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .PIXEL_WIDTH (PIXEL_WIDTH)
  ) u_window (
    .clk           (clk),
    .rst           (rst),
    .en            (adv),
    .in_valid      (items.valid),
    .opcode        (items.opcode),
    .channel_index (items.channel_index),
    .pixel_value   (items.pixel_value),
    .weight_bits   (items.weight_bits),
    .image_width   (image_width),
    .image_height  (image_height),
    .head_ctl      (chain_ctl[0]),
    .head_win      (chain_win[0])
  );

  assign chain_bits[0] = '0;

  // Chain of channel cells; each one adds its own bit to the result vector.
  for (genvar c = 0; c < CHANNELS; c++) begin : g_cell
    bwct_cell #(
      .KERNEL_SIZE (KERNEL_SIZE),
      .PIXEL_WIDTH (PIXEL_WIDTH),
      .CHANNELS    (CHANNELS),
      .CELL_ID     (c)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (adv),
      .a_ctl  (chain_ctl[c]),
      .a_win  (chain_win[c]),
      .a_bits (chain_bits[c]),
      .o_ctl  (chain_ctl[c+1]),
      .o_win  (chain_win[c+1]),
      .o_bits (chain_bits[c+1])
    );
  end

  // Output register: only pixels with a full window reach it as results.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= chain_ctl[CHANNELS].valid && (chain_ctl[CHANNELS].op == bwct_pkg::OP_PIXEL);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_bits <= bwct_pkg::CHANNEL_BITS_W'(chain_bits[CHANNELS]);
      res_last <= chain_ctl[CHANNELS].last;
    end
  end

  assign results.valid        = res_valid;
  assign results.channel_bits = res_bits;
  assign results.frame_last   = res_last;

  `BWCT_ASSERT_NOW(a_stall_blocks_input, clk, rst, results.valid && !results.ready, !items.ready)
  `BWCT_ASSERT_NOW(a_no_result_after_reset, clk, rst, $past(rst), !results.valid)

endmodule
